// File: hw/rtl/mce_pkg.sv
// types, constants and handshake structs shared by the cell encoder modules
package mce_pkg;

   // request function codes
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_BYTE   = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PRBS_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRBS_SEED      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_LEN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_BYTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LEN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TICKS     = 3'd5;

   // configuration reset values
   localparam logic        RST_PRBS_ENABLE    = 1'b1;
   localparam logic [8:0]  RST_PRBS_SEED      = 9'd1;
   localparam logic [6:0]  RST_WARMUP_LEN     = 7'd32;
   localparam logic [3:0]  RST_PREAMBLE_BYTES = 4'd4;
   localparam logic [5:0]  RST_GAP_LEN        = 6'd8;
   localparam logic [15:0] RST_HIGH_TICKS     = 16'd100;

   // limits on cell counts
   localparam logic [6:0] WARMUP_MAX = 7'd64;
   localparam logic [5:0] GAP_MAX    = 6'd62;
   localparam logic [3:0] BYTE_COUNT_MAX = 4'd15;
   localparam logic [15:0] COUNT_MAX = 16'hffff;

   // fnv-1a constants
   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        cell_level;
      logic [15:0] compare_word;
      logic        run_last;
      logic [31:0] fnv_checksum;
      logic [15:0] high_count;
      logic [15:0] low_count;
   } rsp_type;

   typedef struct packed {
      logic        prbs_enable;
      logic [8:0]  prbs_seed;
      logic [6:0]  warmup_len;
      logic [3:0]  preamble_bytes;
      logic [5:0]  gap_len;
      logic [15:0] high_ticks;
   } cfg_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_cells;
      logic last_cell;
      logic out_free;
   } stat_type;

endpackage

// File: hw/rtl/mce_csr.sv
// configuration register file of the cell encoder
module mce_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mce_pkg::CSR_DATA_W-1:0]    csr_data,
   output mce_pkg::cfg_type                  cfg
);

   mce_pkg::cfg_type cfg_ff;
   mce_pkg::cfg_type cfg_in;

   // registers are always writable
   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // decode the register index, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mce_pkg::CSR_PRBS_ENABLE:    cfg_in.prbs_enable    = csr_data[0];
            mce_pkg::CSR_PRBS_SEED:      cfg_in.prbs_seed      = csr_data[8:0];
            mce_pkg::CSR_WARMUP_LEN:     cfg_in.warmup_len     = csr_data[6:0];
            mce_pkg::CSR_PREAMBLE_BYTES: cfg_in.preamble_bytes = csr_data[3:0];
            mce_pkg::CSR_GAP_LEN:        cfg_in.gap_len        = csr_data[5:0];
            mce_pkg::CSR_HIGH_TICKS:     cfg_in.high_ticks     = csr_data[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prbs_enable    <= mce_pkg::RST_PRBS_ENABLE;
         cfg_ff.prbs_seed      <= mce_pkg::RST_PRBS_SEED;
         cfg_ff.warmup_len     <= mce_pkg::RST_WARMUP_LEN;
         cfg_ff.preamble_bytes <= mce_pkg::RST_PREAMBLE_BYTES;
         cfg_ff.gap_len        <= mce_pkg::RST_GAP_LEN;
         cfg_ff.high_ticks     <= mce_pkg::RST_HIGH_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/mce_ctrl.sv
// controller state machine: accepts a request, then steps out its cells
module mce_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mce_pkg::stat_type stat,
   output mce_pkg::cmd_type  cmd
);

   mce_pkg::state_type state_ff;
   mce_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mce_pkg::ST_IDLE: begin
            if (req_valid && stat.has_cells) state_in = mce_pkg::ST_EMIT;
         end
         mce_pkg::ST_EMIT: begin
            if (stat.out_free && stat.last_cell) state_in = mce_pkg::ST_IDLE;
         end
         default: state_in = mce_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         mce_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mce_pkg::ST_EMIT: begin
            cmd.step = stat.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mce_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/mce_dp.sv
// datapath: cell generator, warm-up lfsr, statistics and result register
module mce_dp #(
   parameter int MAX_RUN = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  mce_pkg::cfg_type  cfg,
   input  mce_pkg::req_type  req_payload,
   input  mce_pkg::cmd_type  cmd,
   output mce_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mce_pkg::rsp_type  rsp_payload
);

   localparam logic [2:0] MaxRun = 3'(MAX_RUN);

   // item sequencing
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  mode_ff, mode_in;
   logic        raw_ff, raw_in;
   logic        phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  byte_count_ff, byte_count_in;
   // warm-up generator
   logic [8:0]  lfsr_ff, lfsr_in;
   logic        last_bit_ff, last_bit_in;
   logic [2:0]  run_length_ff, run_length_in;
   logic        pair_pending_ff, pair_pending_in;
   logic        pair_bit_ff, pair_bit_in;
   logic        alt_phase_ff, alt_phase_in;
   // statistics
   logic [31:0] chk_ff, chk_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;
   // result register
   logic             out_valid_ff, out_valid_in;
   mce_pkg::rsp_type out_ff, out_in;

   logic        raw_now;
   logic [6:0]  item_cells;
   logic [6:0]  warm_cap;
   logic [5:0]  gap_cap;
   logic [8:0]  lfsr_next;
   logic        gen_bit;
   logic        level;
   logic [15:0] word;
   logic [31:0] chk_mix;

   // cell count of the offered request
   always_comb begin
      raw_now  = byte_count_ff < cfg.preamble_bytes;
      warm_cap = (cfg.warmup_len > mce_pkg::WARMUP_MAX) ? mce_pkg::WARMUP_MAX
                                                        : cfg.warmup_len;
      gap_cap  = (cfg.gap_len > mce_pkg::GAP_MAX) ? mce_pkg::GAP_MAX : cfg.gap_len;
      case (req_payload.func)
         mce_pkg::FUNC_START:  item_cells = warm_cap;
         mce_pkg::FUNC_BYTE:   item_cells = raw_now ? 7'd8 : 7'd16;
         mce_pkg::FUNC_FINISH: item_cells = 7'(gap_cap) + 7'd2;
         default:              item_cells = 7'd0;
      endcase
   end

   // status to the controller
   always_comb begin
      stat.has_cells = item_cells != 7'd0;
      stat.last_cell = cnt_ff == 7'd1;
      stat.out_free  = !out_valid_ff || !rsp_stall;
   end

   // lfsr step with the run limit applied
   always_comb begin
      lfsr_next = {lfsr_ff[7:0], lfsr_ff[8] ^ lfsr_ff[4]};
      gen_bit   = lfsr_next[0];
      if (run_length_ff >= MaxRun && gen_bit == last_bit_ff) gen_bit = !last_bit_ff;
   end

   // level of the current cell
   always_comb begin
      case (mode_ff)
         mce_pkg::FUNC_START: begin
            if (!cfg.prbs_enable) level = !alt_phase_ff;
            else if (pair_pending_ff) level = pair_bit_ff;
            else level = !gen_bit;
         end
         mce_pkg::FUNC_BYTE: level = (raw_ff || phase_ff) ? shift_ff[7] : !shift_ff[7];
         default:            level = 1'b0;
      endcase
      word    = level ? cfg.high_ticks : 16'd0;
      chk_mix = chk_ff ^ {16'd0, word};
   end

   // state update on load and step
   always_comb begin
      cnt_in          = cnt_ff;
      mode_in         = mode_ff;
      raw_in          = raw_ff;
      phase_in        = phase_ff;
      shift_in        = shift_ff;
      byte_count_in   = byte_count_ff;
      lfsr_in         = lfsr_ff;
      last_bit_in     = last_bit_ff;
      run_length_in   = run_length_ff;
      pair_pending_in = pair_pending_ff;
      pair_bit_in     = pair_bit_ff;
      alt_phase_in    = alt_phase_ff;
      chk_in          = chk_ff;
      high_in         = high_ff;
      low_in          = low_ff;
      out_valid_in    = out_valid_ff && rsp_stall;
      out_in          = out_ff;

      if (cmd.load) begin
         cnt_in  = item_cells;
         mode_in = req_payload.func;
         case (req_payload.func)
            mce_pkg::FUNC_START: begin
               lfsr_in         = cfg.prbs_seed;
               last_bit_in     = 1'b0;
               run_length_in   = 3'd0;
               pair_pending_in = 1'b0;
               pair_bit_in     = 1'b0;
               alt_phase_in    = 1'b0;
               byte_count_in   = 4'd0;
               chk_in          = mce_pkg::FNV_OFFSET;
               high_in         = 16'd0;
               low_in          = 16'd0;
            end
            mce_pkg::FUNC_BYTE: begin
               raw_in   = raw_now;
               phase_in = 1'b0;
               shift_in = req_payload.data_byte;
               if (byte_count_ff != mce_pkg::BYTE_COUNT_MAX)
                  byte_count_in = byte_count_ff + 4'd1;
            end
            default: cnt_in = item_cells;
         endcase
      end

      if (cmd.step) begin
         cnt_in = cnt_ff - 7'd1;
         // advance the source of the cell
         case (mode_ff)
            mce_pkg::FUNC_START: begin
               if (!cfg.prbs_enable) begin
                  alt_phase_in = !alt_phase_ff;
               end else if (pair_pending_ff) begin
                  pair_pending_in = 1'b0;
               end else begin
                  lfsr_in         = lfsr_next;
                  run_length_in   = (gen_bit == last_bit_ff) ? run_length_ff + 3'd1 : 3'd1;
                  last_bit_in     = gen_bit;
                  pair_bit_in     = gen_bit;
                  pair_pending_in = 1'b1;
               end
            end
            mce_pkg::FUNC_BYTE: begin
               if (raw_ff || phase_ff) shift_in = {shift_ff[6:0], 1'b0};
               if (!raw_ff) phase_in = !phase_ff;
            end
            default: phase_in = phase_ff;
         endcase
         // statistics
         if (word == cfg.high_ticks) begin
            if (high_ff != mce_pkg::COUNT_MAX) high_in = high_ff + 16'd1;
         end else begin
            if (low_ff != mce_pkg::COUNT_MAX) low_in = low_ff + 16'd1;
         end
         chk_in = 32'(chk_mix * mce_pkg::FNV_PRIME);
         // result register
         out_valid_in        = 1'b1;
         out_in.cell_level   = level;
         out_in.compare_word = word;
         out_in.run_last     = cnt_ff == 7'd1;
         out_in.fnv_checksum = chk_in;
         out_in.high_count   = high_in;
         out_in.low_count    = low_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff          <= 7'd0;
         mode_ff         <= mce_pkg::FUNC_FINISH;
         raw_ff          <= 1'b0;
         phase_ff        <= 1'b0;
         byte_count_ff   <= 4'd0;
         lfsr_ff         <= mce_pkg::RST_PRBS_SEED;
         last_bit_ff     <= 1'b0;
         run_length_ff   <= 3'd0;
         pair_pending_ff <= 1'b0;
         pair_bit_ff     <= 1'b0;
         alt_phase_ff    <= 1'b0;
         chk_ff          <= mce_pkg::FNV_OFFSET;
         high_ff         <= 16'd0;
         low_ff          <= 16'd0;
         out_valid_ff    <= 1'b0;
      end else begin
         cnt_ff          <= cnt_in;
         mode_ff         <= mode_in;
         raw_ff          <= raw_in;
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         lfsr_ff         <= lfsr_in;
         last_bit_ff     <= last_bit_in;
         run_length_ff   <= run_length_in;
         pair_pending_ff <= pair_pending_in;
         pair_bit_ff     <= pair_bit_in;
         alt_phase_ff    <= alt_phase_in;
         chk_ff          <= chk_in;
         high_ff         <= high_in;
         low_ff          <= low_in;
         out_valid_ff    <= out_valid_in;
      end
      shift_ff <= shift_in;
      out_ff   <= out_in;
   end

endmodule

// File: hw/rtl/manchester_cell_encoder_with_warmup_unit.sv
// top level of the manchester cell encoder with warm-up
// sequencing: after acceptance the controller enters its emit state and each step registers a cell
//    in the result register; a request has N cells (16 for a manchester byte, 8 for a preamble byte,
//    min(warmup,64) for start, min(gap,62)+2 for finish) and the next is taken after its last cell
// the single result register is filled with one cell per cycle while the output is not stalled
// reset: synchronous, registers to their defaults, generator and statistics cleared
module manchester_cell_encoder_with_warmup_unit #(
   parameter int MAX_RUN = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mce_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mce_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mce_pkg::CSR_DATA_W-1:0] csr_data
);

   mce_pkg::cfg_type  cfg;
   mce_pkg::cmd_type  cmd;
   mce_pkg::stat_type stat;

   // configuration registers
   mce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // controller
   mce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   mce_dp #(
      .MAX_RUN (MAX_RUN)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // controller goes back to accepting after the last cell of a request
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.step && stat.last_cell |=> !req_stall)
      else $error("encoder not idle after last cell");

   // a request with cells keeps the input side stalled
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load && stat.has_cells |=> req_stall)
      else $error("encoder accepted a request while emitting");

   // every step lands a result in the output register
   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid)
      else $error("stepped cell not presented");

endmodule
